@@ src/adfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package adfr_pkg;

  // defaults for the top-level parameters
  localparam int DEFAULT_UNIVERSE_COUNT = 4;
  localparam int DEFAULT_MAX_SLOTS      = 512;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // fixed byte positions within the ethernet frame
  localparam logic [10:0] POS_PROTO   = 11'd23;
  localparam logic [10:0] POS_SIG     = 11'd42;
  localparam logic [10:0] POS_SIG_END = 11'd49;
  localparam logic [10:0] POS_OP_LO   = 11'd50;
  localparam logic [10:0] POS_OP_HI   = 11'd51;
  localparam logic [10:0] POS_UNI_LO  = 11'd56;
  localparam logic [10:0] POS_UNI_HI  = 11'd57;
  localparam logic [10:0] POS_LEN_HI  = 11'd58;
  localparam logic [10:0] POS_LEN_LO  = 11'd59;
  localparam logic [10:0] POS_DATA    = 11'd60;
  localparam logic [10:0] POS_LIMIT   = 11'd2047;

  // header values
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [15:0] ARTNET_OP_DMX = 16'h5000;
  localparam logic [7:0]  LEN_HI_LIMIT  = 8'd3;

  // result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] universe;
    logic [8:0] slot;
    logic [7:0] level;
    logic       last_of_run;
  } out_word_t;

  // one classified byte, carried from front to back
  typedef struct packed {
    logic       has_write;
    logic       has_event;
    logic [1:0] universe;
    logic [8:0] slot;
    logic [7:0] level;
  } op_t;

  // "Art-Net" signature, one character per index
  function automatic logic [7:0] sig_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h2D;
      3'd4:    c = 8'h4E;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/adfr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adfr_front #(
  parameter int UNIVERSE_COUNT = adfr_pkg::DEFAULT_UNIVERSE_COUNT,
  parameter int MAX_SLOTS      = adfr_pkg::DEFAULT_MAX_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire adfr_pkg::in_word_t frame,
  output logic                   op_valid,
  output adfr_pkg::op_t          op
);

  logic [10:0] byte_position, byte_position_next;
  logic        protocol_ok, protocol_ok_next;
  logic        signature_ok, signature_ok_next;
  logic [15:0] opcode_capture, opcode_capture_next;
  logic [15:0] universe_capture, universe_capture_next;
  logic [9:0]  slot_count, slot_count_next;

  logic [10:0] sig_off;
  logic [10:0] data_off;
  logic [9:0]  len;
  logic        sig_match;
  logic        header_match;
  logic        write_hit;
  logic        event_hit;

  always_comb begin
    byte_position_next    = byte_position;
    protocol_ok_next      = protocol_ok;
    signature_ok_next     = signature_ok;
    opcode_capture_next   = opcode_capture;
    universe_capture_next = universe_capture;
    slot_count_next       = slot_count;

    sig_off   = byte_position - adfr_pkg::POS_SIG;
    data_off  = byte_position - adfr_pkg::POS_DATA;
    len       = {slot_count[1:0], frame.frame_byte};
    sig_match = (frame.frame_byte == adfr_pkg::sig_char(sig_off[2:0]));

    if (byte_position == adfr_pkg::POS_PROTO) begin
      protocol_ok_next = (frame.frame_byte == adfr_pkg::IP_PROTO_UDP);
    end else if (byte_position >= adfr_pkg::POS_SIG &&
                 byte_position < adfr_pkg::POS_SIG_END) begin
      signature_ok_next = (byte_position == adfr_pkg::POS_SIG) ? sig_match
                                                               : (signature_ok && sig_match);
    end else if (byte_position == adfr_pkg::POS_OP_LO) begin
      opcode_capture_next = {opcode_capture[15:8], frame.frame_byte};
    end else if (byte_position == adfr_pkg::POS_OP_HI) begin
      opcode_capture_next = {frame.frame_byte, opcode_capture[7:0]};
    end else if (byte_position == adfr_pkg::POS_UNI_LO) begin
      universe_capture_next = {universe_capture[15:8], frame.frame_byte};
    end else if (byte_position == adfr_pkg::POS_UNI_HI) begin
      universe_capture_next = {frame.frame_byte, universe_capture[7:0]};
    end else if (byte_position == adfr_pkg::POS_LEN_HI) begin
      slot_count_next = (frame.frame_byte > adfr_pkg::LEN_HI_LIMIT)
                        ? {2'b00, adfr_pkg::LEN_HI_LIMIT}
                        : {2'b00, frame.frame_byte};
    end else if (byte_position == adfr_pkg::POS_LEN_LO) begin
      slot_count_next = (len > 10'(MAX_SLOTS)) ? 10'(MAX_SLOTS) : len;
    end

    // all header fields are final once the length low byte is reached
    header_match = (byte_position >= adfr_pkg::POS_LEN_LO) && protocol_ok && signature_ok &&
                   (opcode_capture == adfr_pkg::ARTNET_OP_DMX) &&
                   (universe_capture < 16'(UNIVERSE_COUNT));
    write_hit    = header_match && (byte_position >= adfr_pkg::POS_DATA) &&
                   (data_off < {1'b0, slot_count});
    event_hit    = header_match && frame.frame_end;

    if (frame.frame_end) begin
      byte_position_next    = '0;
      protocol_ok_next      = 1'b0;
      signature_ok_next     = 1'b0;
      opcode_capture_next   = '0;
      universe_capture_next = '0;
      slot_count_next       = '0;
    end else if (byte_position < adfr_pkg::POS_LIMIT) begin
      byte_position_next = byte_position + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      protocol_ok      <= 1'b0;
      signature_ok     <= 1'b0;
      opcode_capture   <= '0;
      universe_capture <= '0;
      slot_count       <= '0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      protocol_ok      <= protocol_ok_next;
      signature_ok     <= signature_ok_next;
      opcode_capture   <= opcode_capture_next;
      universe_capture <= universe_capture_next;
      slot_count       <= slot_count_next;
    end
  end

  assign op_valid     = accept && (write_hit || event_hit);
  assign op.has_write = write_hit;
  assign op.has_event = event_hit;
  assign op.universe  = universe_capture[1:0];
  assign op.slot      = data_off[8:0];
  assign op.level     = frame.frame_byte;

`ifndef ASSERT_OFF
  // a frame end always rewinds the position for the next frame
  a_end_rewinds: assert property (@(posedge clk) disable iff (rst)
    accept && frame.frame_end |=> byte_position == '0)
    else $error("position not cleared after frame end");
`endif

endmodule

`default_nettype wire

@@ src/adfr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adfr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire adfr_pkg::op_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output adfr_pkg::op_t      rd_data,
  output logic               not_empty
);

  localparam int Depth  = adfr_pkg::QUEUE_DEPTH;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  adfr_pkg::op_t     entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + CountW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  assign rd_data   = entries[rd_ptr];
  assign full      = (count == CountW'(Depth));
  assign not_empty = (count != '0);

`ifndef ASSERT_OFF
  // front and back must respect the fill level
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ src/adfr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adfr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire adfr_pkg::op_t q_data,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output adfr_pkg::out_word_t result
);

  adfr_pkg::op_t cur;
  logic          cur_valid;
  logic          both;
  logic          done;

  assign both  = cur.has_write && cur.has_event;
  // the held entry is free once its last word goes
  assign done  = !cur_valid || (pop && !both);
  assign q_pop = done && q_valid;
  assign empty = !cur_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (done) begin
      cur_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end else if (pop && cur_valid && both) begin
      cur.has_write <= 1'b0;
    end
  end

  // write goes out first, the event after it
  assign result.kind        = cur.has_write ? adfr_pkg::KIND_WRITE : adfr_pkg::KIND_EVENT;
  assign result.universe    = cur.universe;
  assign result.slot        = cur.has_write ? cur.slot : '0;
  assign result.level       = cur.has_write ? cur.level : '0;
  assign result.last_of_run = !both;

`ifndef ASSERT_OFF
  // a write that is not last is always followed by its event
  a_event_follows: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && result.kind == adfr_pkg::KIND_WRITE && !result.last_of_run
    |=> !empty && result.kind == adfr_pkg::KIND_EVENT)
    else $error("event lost after write");

  a_event_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == adfr_pkg::KIND_EVENT
    |-> result.slot == '0 && result.level == '0 && result.last_of_run)
    else $error("malformed event word");
`endif

endmodule

`default_nettype wire

@@ src/artnet_dmx_frame_receiver_unit.sv @@
// art-net dmx receiver: takes one ethernet frame byte per word on the frame
// channel (push/full) with frame_end on the final byte, and gives dmx slot
// writes and universe-received events on the result channel (empty/pop)
// input word accepted when push is high and full is low; result word taken
// when pop is high and empty is low, the oldest result shown while empty is low
// a byte of a matching frame inside the slot count gives one slot write; the
// final byte of a matching frame gives an event, after its write if it has one
// with the back end idle, a byte's first result goes into the queue when the
// byte is taken, then into the held result register, where it can be popped
// throughput: one byte per cycle while full is low; the back end gives one
// result word per cycle while pop is high, so a byte giving a write and an
// event holds it for both words; a four-entry queue between front and back
// absorbs that; when the receiver stops popping, the queue fills and full
// rises, and bytes that give no result never occupy the queue
// reset (rst, synchronous) clears the frame parser, the queue and the held
// result, so the block starts at byte zero of a new frame
`timescale 1ns / 1ps
`default_nettype none

module artnet_dmx_frame_receiver_unit #(
  parameter int UNIVERSE_COUNT = adfr_pkg::DEFAULT_UNIVERSE_COUNT,
  parameter int MAX_SLOTS      = adfr_pkg::DEFAULT_MAX_SLOTS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // frame byte channel
  input  wire logic               push,
  output logic                    full,
  input  wire adfr_pkg::in_word_t frame,
  // result channel
  output logic                    empty,
  input  wire logic               pop,
  output adfr_pkg::out_word_t     result
);

  logic          accept;
  logic          op_valid;
  adfr_pkg::op_t op;
  logic          q_pop;
  logic          q_valid;
  adfr_pkg::op_t q_data;

  // bytes are taken whenever the queue has room
  assign accept = push && !full;

  // parser: tracks frame position, checks the header, classifies each byte
  adfr_front #(
    .UNIVERSE_COUNT (UNIVERSE_COUNT),
    .MAX_SLOTS      (MAX_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .frame    (frame),
    .op_valid (op_valid),
    .op       (op)
  );

  // decouples the parser from a stalled receiver
  adfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (op_valid),
    .wr_data   (op),
    .full      (full),
    .rd_en     (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid)
  );

  // expands each classified byte into one or two result words
  adfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // cycles with no word moving on either side before the run is called hung;
  // the longest legal quiet stretch is the receiver hold-off plus a long gap
  localparam int STALL_LIMIT = 3000;
  // receiver hold-off, long enough to fill the internal queue several times over
  localparam int HOLD_OFF_CYCLES = 400;
  // the hold-off starts once this many result words have been taken
  localparam int HOLD_OFF_AFTER = 10;
  // frame bytes in the whole run at least, directed part included
  localparam int ITEM_COUNT = 950;
  // signature text, first character in the top byte
  localparam logic [55:0] ARTNET_TEXT = "Art-Net";

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  adfr_pkg::in_word_t  frame = '0;
  logic                full;
  logic                empty;
  adfr_pkg::out_word_t result;

  artnet_dmx_frame_receiver_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .frame  (frame),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // frame bytes waiting to be offered, and result words still owed by the block
  adfr_pkg::in_word_t  frame_bytes_pending[$];
  adfr_pkg::out_word_t dmx_results_due[$];

  int   errors = 0;
  int   results_taken = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;

  // parser state as the block should hold it
  logic [10:0] rx_pos;
  logic        rx_proto_ok;
  logic        rx_sig_ok;
  logic [15:0] rx_opcode;
  logic [15:0] rx_universe;
  logic [9:0]  rx_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame parser model
  // ---------------------------------------------------------------------------

  // state goes back to byte zero after reset and after every final byte
  function automatic void clear_frame_state();
    rx_pos      = '0;
    rx_proto_ok = 1'b0;
    rx_sig_ok   = 1'b0;
    rx_opcode   = '0;
    rx_universe = '0;
    rx_count    = '0;
  endfunction

  // takes one accepted frame byte and queues the result words it should give
  function automatic void decode_frame_byte(input adfr_pkg::in_word_t w);
    logic [10:0]         p;
    logic [9:0]          len;
    logic                hit;
    logic                header_ok;
    adfr_pkg::out_word_t r;
    int                  idx;
    p = rx_pos;
    if (p == adfr_pkg::POS_PROTO) begin
      rx_proto_ok = (w.frame_byte == adfr_pkg::IP_PROTO_UDP);
    end else if (p >= adfr_pkg::POS_SIG && p < adfr_pkg::POS_SIG_END) begin
      idx = p - adfr_pkg::POS_SIG;
      hit = (w.frame_byte == ARTNET_TEXT[8 * (6 - idx) +: 8]);
      // first character restarts the match, the rest can only spoil it
      rx_sig_ok = (p == adfr_pkg::POS_SIG) ? hit : (rx_sig_ok && hit);
    end else if (p == adfr_pkg::POS_OP_LO) begin
      rx_opcode[7:0] = w.frame_byte;
    end else if (p == adfr_pkg::POS_OP_HI) begin
      rx_opcode[15:8] = w.frame_byte;
    end else if (p == adfr_pkg::POS_UNI_LO) begin
      rx_universe[7:0] = w.frame_byte;
    end else if (p == adfr_pkg::POS_UNI_HI) begin
      rx_universe[15:8] = w.frame_byte;
    end else if (p == adfr_pkg::POS_LEN_HI) begin
      // high byte of the slot count is clipped before the low byte arrives
      rx_count = (w.frame_byte > adfr_pkg::LEN_HI_LIMIT) ? 10'(adfr_pkg::LEN_HI_LIMIT)
                                                         : 10'(w.frame_byte);
    end else if (p == adfr_pkg::POS_LEN_LO) begin
      len = {rx_count[1:0], w.frame_byte};
      rx_count = (len > adfr_pkg::DEFAULT_MAX_SLOTS) ? 10'(adfr_pkg::DEFAULT_MAX_SLOTS) : len;
    end

    header_ok = (p >= adfr_pkg::POS_LEN_LO) && rx_proto_ok && rx_sig_ok &&
                (rx_opcode == adfr_pkg::ARTNET_OP_DMX) &&
                (rx_universe < adfr_pkg::DEFAULT_UNIVERSE_COUNT);

    // slot write for data bytes inside the count; bytes past it are dropped
    if (header_ok && p >= adfr_pkg::POS_DATA && (p - adfr_pkg::POS_DATA) < rx_count) begin
      r.kind        = adfr_pkg::KIND_WRITE;
      r.universe    = rx_universe[1:0];
      r.slot        = 9'(p - adfr_pkg::POS_DATA);
      r.level       = w.frame_byte;
      r.last_of_run = !w.frame_end;
      dmx_results_due.push_back(r);
    end
    // final byte of a matching frame: event, behind its write if there is one
    if (header_ok && w.frame_end) begin
      r.kind        = adfr_pkg::KIND_EVENT;
      r.universe    = rx_universe[1:0];
      r.slot        = '0;
      r.level       = '0;
      r.last_of_run = 1'b1;
      dmx_results_due.push_back(r);
    end

    if (w.frame_end) begin
      clear_frame_state();
    end else if (rx_pos != adfr_pkg::POS_LIMIT) begin
      rx_pos = rx_pos + 11'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] value, input logic last);
    adfr_pkg::in_word_t w;
    w.frame_byte = value;
    w.frame_end  = last;
    frame_bytes_pending.push_back(w);
  endfunction

  // one frame of total bytes with the given header fields and random filler;
  // bad_sig picks a signature character to spoil, or none when negative
  function automatic void add_frame(input logic [7:0] proto, input int bad_sig,
                                    input logic [15:0] opcode, input logic [15:0] univ,
                                    input logic [15:0] count, input int total,
                                    input bit extreme_levels);
    logic [7:0] b;
    for (int p = 0; p < total; p++) begin
      b = 8'($urandom_range(0, 255));
      if (p == adfr_pkg::POS_PROTO) begin
        b = proto;
      end else if (p >= adfr_pkg::POS_SIG && p < adfr_pkg::POS_SIG_END) begin
        b = ARTNET_TEXT[8 * (6 - (p - adfr_pkg::POS_SIG)) +: 8];
        if (p - adfr_pkg::POS_SIG == bad_sig) b = b ^ 8'h20;
      end else if (p == adfr_pkg::POS_OP_LO) begin
        b = opcode[7:0];
      end else if (p == adfr_pkg::POS_OP_HI) begin
        b = opcode[15:8];
      end else if (p == adfr_pkg::POS_UNI_LO) begin
        b = univ[7:0];
      end else if (p == adfr_pkg::POS_UNI_HI) begin
        b = univ[15:8];
      end else if (p == adfr_pkg::POS_LEN_HI) begin
        b = count[15:8];
      end else if (p == adfr_pkg::POS_LEN_LO) begin
        b = count[7:0];
      end else if (extreme_levels && p == adfr_pkg::POS_DATA) begin
        b = 8'h00;
      end else if (extreme_levels && p == adfr_pkg::POS_DATA + 1) begin
        b = 8'hFF;
      end
      add_byte(b, p == total - 1);
    end
  endfunction

  // gap before the next word: mostly none or short, now and then long, and
  // every so often a calm stretch with no gaps at all
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(30, 150);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers the pending bytes, inputs change on the falling edge
  // ---------------------------------------------------------------------------

  int tx_gap = 0;
  int tx_calm = 0;

  always @(negedge clk) begin
    if (rst) begin
      push  <= 1'b0;
      frame <= '0;
    end else if (!push || in_taken) begin
      // the current word is gone (or none was up), so pick what comes next
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (frame_bytes_pending.size() > 0) begin
        frame  <= frame_bytes_pending.pop_front();
        push   <= 1'b1;
        tx_gap = pick_gap(tx_calm);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random pop gaps plus one long hold-off to fill the block up
  // ---------------------------------------------------------------------------

  int rx_gap = 0;
  int rx_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!hold_done && results_taken >= HOLD_OFF_AFTER) begin
      // sender keeps offering bytes meanwhile, so full has to rise
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop <= 1'b0;
    end else begin
      pop    <= 1'b1;
      rx_gap = pick_gap(rx_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    adfr_pkg::out_word_t want;
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles = 0;
      clear_frame_state();
    end else begin
      in_taken <= push && !full;
      // prediction first, though no result can come out on the same edge
      if (push && !full) decode_frame_byte(frame);
      if (pop && !empty) begin
        results_taken++;
        if (dmx_results_due.size() == 0) begin
          $error("result word with nothing expected: kind %0d universe %0d slot %0d level %0d",
                 result.kind, result.universe, result.slot, result.level);
          errors++;
        end else begin
          want = dmx_results_due.pop_front();
          check_field("kind", 16'(want.kind), 16'(result.kind));
          check_field("universe", 16'(want.universe), 16'(result.universe));
          check_field("slot", 16'(want.slot), 16'(result.slot));
          check_field("level", 16'(want.level), 16'(result.level));
          check_field("last_of_run", 16'(want.last_of_run), 16'(result.last_of_run));
        end
      end
      // watchdog on cycles where no word moves either way
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int          r;
    int          fault;
    int          total;
    int          span_max;
    int          bad;
    logic [15:0] cnt;
    logic [15:0] univ;
    logic [15:0] op;
    logic [7:0]  proto;

    // directed: one-byte frames at both byte extremes
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    // write and event on the same final byte
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd0, 16'd3, 63, 1'b1);
    // high count byte clipped, then the whole count clipped to the maximum
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd3, 16'hFFFF, 66, 1'b1);
    // high count byte within limit but total above the maximum
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd1, 16'h0203, 66, 1'b0);
    // frame ending inside the data
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd2, 16'd8, 62, 1'b0);
    // ends before the low count byte: nothing at all
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd1, 16'd4, 59, 1'b0);
    // ends on the low count byte: event only
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd1, 16'd4, 60, 1'b0);
    // bytes past the count are dropped
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd0, 16'd2, 70, 1'b0);
    // zero count: event only
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd3, 16'd0, 62, 1'b0);
    // rejected headers, one fault each
    add_frame(8'd6, -1, adfr_pkg::ARTNET_OP_DMX, 16'd0, 16'd4, 64, 1'b0);
    add_frame(adfr_pkg::IP_PROTO_UDP, 0, adfr_pkg::ARTNET_OP_DMX, 16'd0, 16'd4, 64, 1'b0);
    add_frame(adfr_pkg::IP_PROTO_UDP, 6, adfr_pkg::ARTNET_OP_DMX, 16'd0, 16'd4, 64, 1'b0);
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, 16'h5001, 16'd0, 16'd4, 64, 1'b0);
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'd4, 16'd4, 64, 1'b0);
    add_frame(adfr_pkg::IP_PROTO_UDP, -1, adfr_pkg::ARTNET_OP_DMX, 16'h0100, 16'd4, 64, 1'b0);

    // random: mostly good frames with random content, some with one fault,
    // some plain noise, until the byte budget is used up
    while (frame_bytes_pending.size() < ITEM_COUNT) begin
      r = $urandom_range(0, 99);
      if (r >= 90) begin
        total = $urandom_range(1, 80);
        for (int i = 0; i < total; i++) add_byte(8'($urandom_range(0, 255)), i == total - 1);
      end else begin
        fault = $urandom_range(0, 99);
        if (fault < 80) cnt = 16'($urandom_range(0, 16));
        else if (fault < 95) cnt = 16'($urandom_range(17, 64));
        else cnt = 16'($urandom_range(0, 65535));
        span_max = (cnt > 40) ? 44 : int'(cnt) + 4;
        total = 60 + $urandom_range(0, span_max);
        if ($urandom_range(0, 9) == 0) total = $urandom_range(1, 59);
        proto = adfr_pkg::IP_PROTO_UDP;
        bad   = -1;
        op    = adfr_pkg::ARTNET_OP_DMX;
        univ  = 16'($urandom_range(0, adfr_pkg::DEFAULT_UNIVERSE_COUNT - 1));
        if (r >= 70) begin
          fault = $urandom_range(0, 3);
          if (fault == 0) begin
            proto = 8'($urandom_range(0, 255));
            if (proto == adfr_pkg::IP_PROTO_UDP) proto = proto ^ 8'h01;
          end else if (fault == 1) begin
            bad = $urandom_range(0, 6);
          end else if (fault == 2) begin
            op = op ^ (16'h0001 << $urandom_range(0, 15));
          end else begin
            univ = 16'($urandom_range(adfr_pkg::DEFAULT_UNIVERSE_COUNT, 65535));
          end
        end
        add_frame(proto, bad, op, univ, cnt, total, 1'b0);
      end
    end

    // reset held from the start of the run, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: every byte taken, every result word back, then a short settle
    wait (frame_bytes_pending.size() == 0 && !push);
    wait (dmx_results_due.size() == 0);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
